// ===== rtl/core/decimal_fir_filter_8_tap_top_defines.svh =====
// Assertion macros shared by the decimal FIR filter RTL.
`ifndef DECIMAL_FIR_FILTER_8_TAP_TOP_DEFINES_SVH
`define DECIMAL_FIR_FILTER_8_TAP_TOP_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled while rst is high.
`define DFIR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dfir check failed");

// Next-cycle implication, checked on clk and disabled while rst is high.
`define DFIR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dfir check failed");

`endif

// ===== rtl/core/dfir_pkg.sv =====
// Types, constants and helper functions for the decimal FIR filter.
`timescale 1ns / 1ps

package dfir_pkg;

  typedef enum logic [1:0] {
    REG_COEF_OUTER  = 2'd0,
    REG_COEF_SECOND = 2'd1,
    REG_COEF_THIRD  = 2'd2,
    REG_COEF_CENTER = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [3:0] tens;
    logic [3:0] units;
  } digit_pair_t;

  localparam int unsigned NUM_LANES = 4;
  localparam int unsigned HIST_DEPTH = 7;

  localparam logic signed [15:0] COEF_OUTER_RST  = 16'sd875;
  localparam logic signed [15:0] COEF_SECOND_RST = 16'sd4794;
  localparam logic signed [15:0] COEF_THIRD_RST  = 16'sd16402;
  localparam logic signed [15:0] COEF_CENTER_RST = 16'sd27927;

  localparam logic [13:0] OUT_MAX = 14'd9999;
  localparam logic [5:0] ASCII_ZERO = 6'd48;

  // A sum of -99999 or above truncates to a quotient of zero or more.
  localparam logic signed [32:0] SUM_LOW = -33'sd99999;
  // Quotients above 9999 start at a sum of 10000 * 100000.
  localparam logic signed [32:0] SUM_HIGH = 33'sd1000000000;

  // floor(x / 3125) for x below 2^25 equals (x * SCALE_RECIP) >> 37.
  localparam logic [25:0] SCALE_RECIP = 26'd43980466;
  // floor(x / 100) for x below 2^14 equals (x * HUND_RECIP) >> 20.
  localparam logic [13:0] HUND_RECIP = 14'd10486;
  // floor(x / 10) for x below 2^7 equals (x * TEN_RECIP) >> 10.
  localparam logic [9:0] TEN_RECIP = 10'd103;

  // A character maps to its low nibble, clamped to nine.
  function automatic logic [3:0] char_digit(input logic [5:0] c);
    logic [3:0] d;
    d = c[3:0];
    return (d > 4'd9) ? 4'd9 : d;
  endfunction

  function automatic logic [5:0] ascii_digit(input logic [3:0] d);
    return ASCII_ZERO + {2'd0, d};
  endfunction

  // Splits a value in 0..99 into its two decimal digits.
  function automatic digit_pair_t split_tens(input logic [6:0] x);
    logic [16:0] prod;
    logic [6:0] rem;
    digit_pair_t res;
    prod = {10'd0, x} * {7'd0, TEN_RECIP};
    res.tens = prod[13:10];
    rem = x - ({3'd0, res.tens} * 7'd10);
    res.units = rem[3:0];
    return res;
  endfunction

endpackage

// ===== rtl/core/decimal_fir_filter_8_tap_top.sv =====
// An item's result is valid once the item has passed through stages A to H.
// Throughput: one item per cycle unless out_ready is low; each stage holds one
// item and moves on when the stage after it is empty or moving, so bubbles
// close up under stalls. The 16x16 tap products and the 25x26 reciprocal
// multiply set the clock. Reset clears the sample history to zero, loads the
// default coefficients and empties the pipeline.
`timescale 1ns / 1ps
`include "decimal_fir_filter_8_tap_top_defines.svh"

module decimal_fir_filter_8_tap_top
  import dfir_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [5:0]  char_thousands,
  input  logic [5:0]  char_hundreds,
  input  logic [5:0]  char_tens,
  input  logic [5:0]  char_units,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [13:0] filtered_value,
  output logic [5:0]  out_thousands,
  output logic [5:0]  out_hundreds,
  output logic [5:0]  out_tens,
  output logic [5:0]  out_units,
  output logic        clipped
);

  localparam int unsigned NUM_STAGES = 8;
  localparam int unsigned ST_A = 0;
  localparam int unsigned ST_B = 1;
  localparam int unsigned ST_C = 2;
  localparam int unsigned ST_D = 3;
  localparam int unsigned ST_E = 4;
  localparam int unsigned ST_F = 5;
  localparam int unsigned ST_G = 6;
  localparam int unsigned ST_H = 7;

  logic signed [15:0] coef [NUM_LANES];
  logic [13:0] hist [HIST_DEPTH];

  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] adv;
  logic accept;

  logic [13:0] sample;
  logic [14:0] a_ps [NUM_LANES];
  logic signed [30:0] mul [NUM_LANES];
  logic signed [30:0] b_prod [NUM_LANES];
  logic signed [31:0] c_s01;
  logic signed [31:0] c_s23;
  logic signed [32:0] d_sum;
  logic [50:0] recip_prod;
  logic [13:0] e_val;
  logic e_clip;
  logic [27:0] hund_prod;
  logic [13:0] f_val;
  logic f_clip;
  logic [6:0] f_hi;
  logic [13:0] f_lo_full;
  digit_pair_t f_hi_dig;
  logic [13:0] g_val;
  logic g_clip;
  logic [6:0] g_lo;
  logic [3:0] g_d3;
  logic [3:0] g_d2;
  digit_pair_t g_lo_dig;
  logic [13:0] out_check;

  // Each stage takes a new item when it is empty or its own item moves on.
  always_comb begin
    adv[ST_H] = !vld[ST_H] || out_ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i + 1];
    end
  end

  assign in_ready = adv[ST_A];
  assign accept = in_valid && in_ready;
  assign out_valid = vld[ST_H];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[ST_A]) begin
        vld[ST_A] <= in_valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i - 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef[REG_COEF_OUTER]  <= COEF_OUTER_RST;
      coef[REG_COEF_SECOND] <= COEF_SECOND_RST;
      coef[REG_COEF_THIRD]  <= COEF_THIRD_RST;
      coef[REG_COEF_CENTER] <= COEF_CENTER_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_COEF_OUTER:  coef[REG_COEF_OUTER]  <= cfg_data;
        REG_COEF_SECOND: coef[REG_COEF_SECOND] <= cfg_data;
        REG_COEF_THIRD:  coef[REG_COEF_THIRD]  <= cfg_data;
        REG_COEF_CENTER: coef[REG_COEF_CENTER] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign sample = {10'd0, char_digit(char_thousands)} * 14'd1000
                + {10'd0, char_digit(char_hundreds)} * 14'd100
                + {10'd0, char_digit(char_tens)} * 14'd10
                + {10'd0, char_digit(char_units)};

  // Oldest sample sits at entry zero; the new sample enters at the top.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist[i] <= '0;
      end
    end else if (accept) begin
      for (int i = 0; i < HIST_DEPTH - 1; i++) begin
        hist[i] <= hist[i + 1];
      end
      hist[HIST_DEPTH - 1] <= sample;
    end
  end

  // Stage A: symmetric tap pairs.
  always_ff @(posedge clk) begin
    if (accept) begin
      a_ps[0] <= {1'b0, hist[0]} + {1'b0, sample};
      a_ps[1] <= {1'b0, hist[1]} + {1'b0, hist[6]};
      a_ps[2] <= {1'b0, hist[2]} + {1'b0, hist[5]};
      a_ps[3] <= {1'b0, hist[3]} + {1'b0, hist[4]};
    end
  end

  // Stage B: one multiplier per lane.
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      mul[i] = 31'(coef[i]) * 31'($signed({1'b0, a_ps[i]}));
    end
  end

  always_ff @(posedge clk) begin
    if (adv[ST_B] && vld[ST_A]) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        b_prod[i] <= mul[i];
      end
    end
  end

  // Stages C and D: adder tree.
  always_ff @(posedge clk) begin
    if (adv[ST_C] && vld[ST_B]) begin
      c_s01 <= {b_prod[0][30], b_prod[0]} + {b_prod[1][30], b_prod[1]};
      c_s23 <= {b_prod[2][30], b_prod[2]} + {b_prod[3][30], b_prod[3]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv[ST_D] && vld[ST_C]) begin
      d_sum <= {c_s01[31], c_s01} + {c_s23[31], c_s23};
    end
  end

  // Stage E: divide by 100000 as a shift by five and a reciprocal multiply
  // by 1/3125; only sums in 0..999999999 reach the quotient path.
  assign recip_prod = {26'd0, d_sum[29:5]} * {25'd0, SCALE_RECIP};

  always_ff @(posedge clk) begin
    if (adv[ST_E] && vld[ST_D]) begin
      if (d_sum < SUM_LOW) begin
        e_val  <= '0;
        e_clip <= 1'b1;
      end else if (d_sum[32]) begin
        e_val  <= '0;
        e_clip <= 1'b0;
      end else if (d_sum >= SUM_HIGH) begin
        e_val  <= OUT_MAX;
        e_clip <= 1'b1;
      end else begin
        e_val  <= recip_prod[50:37];
        e_clip <= 1'b0;
      end
    end
  end

  // Stage F: upper two decimal digits as one value in 0..99.
  assign hund_prod = {14'd0, e_val} * {14'd0, HUND_RECIP};

  always_ff @(posedge clk) begin
    if (adv[ST_F] && vld[ST_E]) begin
      f_val  <= e_val;
      f_clip <= e_clip;
      f_hi   <= hund_prod[26:20];
    end
  end

  // Stage G: lower two digits as a value, upper pair split into digits.
  assign f_lo_full = f_val - ({7'd0, f_hi} * 14'd100);
  assign f_hi_dig = split_tens(f_hi);

  always_ff @(posedge clk) begin
    if (adv[ST_G] && vld[ST_F]) begin
      g_val  <= f_val;
      g_clip <= f_clip;
      g_lo   <= f_lo_full[6:0];
      g_d3   <= f_hi_dig.tens;
      g_d2   <= f_hi_dig.units;
    end
  end

  // Stage H: result register.
  assign g_lo_dig = split_tens(g_lo);

  always_ff @(posedge clk) begin
    if (adv[ST_H] && vld[ST_G]) begin
      filtered_value <= g_val;
      clipped        <= g_clip;
      out_thousands  <= ascii_digit(g_d3);
      out_hundreds   <= ascii_digit(g_d2);
      out_tens       <= ascii_digit(g_lo_dig.tens);
      out_units      <= ascii_digit(g_lo_dig.units);
    end
  end

  assign out_check = {10'd0, out_thousands[3:0]} * 14'd1000
                   + {10'd0, out_hundreds[3:0]} * 14'd100
                   + {10'd0, out_tens[3:0]} * 14'd10
                   + {10'd0, out_units[3:0]};

  `DFIR_ASSERT_NOW(a_digits_match, out_valid, out_check == filtered_value)
  `DFIR_ASSERT_NOW(a_value_range, out_valid, filtered_value <= OUT_MAX)
  `DFIR_ASSERT_NOW(a_clip_bounds, out_valid && clipped,
                   (filtered_value == '0) || (filtered_value == OUT_MAX))
  `DFIR_ASSERT_NEXT(a_stall_holds, vld[ST_E] && !adv[ST_E],
                    vld[ST_E] && $stable(e_val) && $stable(e_clip))

endmodule
